// ===== rtl/core/spd_pkg.sv =====
// Shared types, constants and helper functions of the string pitch period detector.
// The microcode store and the control word layout live here too; the package depends on nothing.
package spd_pkg;

  localparam int unsigned MAX_PERIOD_DEF = 4095;
  localparam int unsigned STEP_W         = 4;

  localparam logic [24:0] HP_LEAK_Q24 = 25'd3355;

  localparam logic [15:0] LP_FREQ_RST  = 16'd3217;
  localparam logic [15:0] LP_DAMP_RST  = 16'd8192;
  localparam logic [12:0] MIN_AMP_RST  = 13'd100;
  localparam logic [15:0] TRIG_FRAC_RST = 16'd52429;
  localparam logic [23:0] ENV_DECAY_RST = 24'd83886;

  typedef enum logic [2:0] {
    CFG_LP_FREQ   = 3'd0,
    CFG_LP_DAMP   = 3'd1,
    CFG_MIN_AMP   = 3'd2,
    CFG_TRIG_FRAC = 3'd3,
    CFG_ENV_DECAY = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_WAIT,
    SEQ_NEXT,
    SEQ_END
  } seq_op_t;

  typedef enum logic [2:0] {
    MA_BAND,
    MA_HP,
    MA_INNER,
    MA_ENVH,
    MA_ENVL
  } a_sel_t;

  typedef enum logic [2:0] {
    MB_FREQ,
    MB_DAMP,
    MB_LEAK,
    MB_DECAY,
    MB_FRAC
  } b_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_HP,
    WB_LOW,
    WB_INNER,
    WB_DC,
    WB_BAND,
    WB_ENVH,
    WB_ENVL,
    WB_TRIGH,
    WB_FINAL
  } wb_op_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    wb_op_t wb;
  } dp_ctrl_t;

  typedef struct packed {
    seq_op_t  seq;
    dp_ctrl_t dp;
  } ucode_t;

  // Each step after the first writes back the product issued by the step before it and issues the next one.
  // The last step issues the product of the step before it again, so that it survives while the step is held.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
    ucode_t w;
    case (s)
      4'd1:    w = '{SEQ_NEXT, '{MA_BAND,  MB_FREQ,  WB_HP}};
      4'd2:    w = '{SEQ_NEXT, '{MA_BAND,  MB_DAMP,  WB_LOW}};
      4'd3:    w = '{SEQ_NEXT, '{MA_HP,    MB_LEAK,  WB_INNER}};
      4'd4:    w = '{SEQ_NEXT, '{MA_INNER, MB_FREQ,  WB_DC}};
      4'd5:    w = '{SEQ_NEXT, '{MA_ENVH,  MB_DECAY, WB_BAND}};
      4'd6:    w = '{SEQ_NEXT, '{MA_ENVL,  MB_DECAY, WB_ENVH}};
      4'd7:    w = '{SEQ_NEXT, '{MA_ENVH,  MB_FRAC,  WB_ENVL}};
      4'd8:    w = '{SEQ_NEXT, '{MA_ENVL,  MB_FRAC,  WB_TRIGH}};
      4'd9:    w = '{SEQ_END,  '{MA_ENVL,  MB_FRAC,  WB_FINAL}};
      default: w = '{SEQ_WAIT, '{MA_BAND,  MB_FREQ,  WB_NONE}};
    endcase
    return w;
  endfunction

  function automatic logic signed [60:0] ext32(input logic signed [31:0] v);
    return {{29{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [60:0] v);
    logic signed [31:0] r;
    if (v > 61'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -61'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Peak-to-peak amplitude in whole ADC counts, clamped to the 13-bit range.
  function automatic logic [12:0] amp_calc(input logic signed [31:0] hi,
                                           input logic signed [31:0] lo);
    logic signed [32:0] d;
    logic signed [16:0] q;
    logic [12:0]        r;
    d = {hi[31], hi} - {lo[31], lo};
    q = d[32:16];
    if (q < 17'sd0) begin
      r = 13'd0;
    end else if (q > 17'sd8191) begin
      r = 13'd8191;
    end else begin
      r = q[12:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/spd_sequencer.sv =====
// Step counter and microcode fetch of the string pitch period detector.
// Depends on spd_pkg for the control word layout and the microcode store.
module spd_sequencer
  import spd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  output logic     done,
  output dp_ctrl_t dp_ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    cw        = ucode_rom(step);
    step_next = step;
    done      = 1'b0;
    in_ready  = 1'b0;
    dp_ctrl   = cw.dp;
    case (cw.seq)
      SEQ_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          step_next = step + STEP_W'(1);
        end
      end
      SEQ_NEXT: begin
        step_next = step + STEP_W'(1);
      end
      SEQ_END: begin
        // The last step holds, with its write-back suppressed, until the output word is free.
        if (out_free) begin
          step_next = '0;
          done      = 1'b1;
        end else begin
          dp_ctrl.wb = WB_NONE;
        end
      end
      default: begin
        step_next = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/spd_datapath.sv =====
// Filter, envelope and trigger datapath around one shared signed 35x25 multiplier.
// Depends on spd_pkg; driven step by step by spd_sequencer.
module spd_datapath
  import spd_pkg::*;
#(
  parameter int unsigned MAX_PERIOD = MAX_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_ctrl_t    dp_ctrl,
  input  logic        load_sample,
  input  logic [11:0] sample,
  input  logic [15:0] lp_freq,
  input  logic [15:0] lp_damp,
  input  logic [12:0] min_amp,
  input  logic [15:0] trig_frac,
  input  logic [23:0] env_decay,
  output logic [11:0] res_period,
  output logic [12:0] res_amp
);

  localparam int unsigned CNT_W = $clog2(MAX_PERIOD + 1);

  logic [11:0]        sample_r;
  logic signed [31:0] hp;
  logic signed [31:0] dc;
  logic signed [31:0] band;
  logic signed [31:0] low;
  logic signed [31:0] envh;
  logic signed [31:0] envl;
  logic signed [34:0] inner;
  logic signed [59:0] prod;
  logic               trig_hi;
  logic               pulse;
  logic [CNT_W-1:0]   count;
  logic [11:0]        held_period;
  logic [12:0]        held_amp;

  logic signed [34:0] a_op;
  logic signed [24:0] b_op;
  logic signed [59:0] shv;
  logic signed [60:0] shv_x;
  logic signed [60:0] low_x;
  logic signed [60:0] inner_sum;
  logic               trig_lo;
  logic [11:0]        fin_period;
  logic [CNT_W-1:0]   fin_count;
  logic               fin_pulse;

  always_comb begin
    case (dp_ctrl.a_sel)
      MA_BAND:  a_op = {{3{band[31]}}, band};
      MA_HP:    a_op = {{3{hp[31]}}, hp};
      MA_INNER: a_op = inner;
      MA_ENVH:  a_op = {{3{envh[31]}}, envh};
      MA_ENVL:  a_op = {{3{envl[31]}}, envl};
      default:  a_op = '0;
    endcase
    case (dp_ctrl.b_sel)
      MB_FREQ:  b_op = {9'd0, lp_freq};
      MB_DAMP:  b_op = {9'd0, lp_damp};
      MB_LEAK:  b_op = HP_LEAK_Q24;
      MB_DECAY: b_op = {1'b0, env_decay};
      MB_FRAC:  b_op = {9'd0, trig_frac};
      default:  b_op = '0;
    endcase
  end

  // Arithmetic shift of the registered product gives the floor-rounded scaling.
  always_comb begin
    case (dp_ctrl.wb)
      WB_INNER:                   shv = prod >>> 14;
      WB_DC, WB_ENVH, WB_ENVL:    shv = prod >>> 24;
      WB_LOW, WB_BAND, WB_TRIGH,
      WB_FINAL:                   shv = prod >>> 16;
      default:                    shv = '0;
    endcase
    shv_x     = {shv[59], shv};
    low_x     = ext32(low);
    inner_sum = ext32(hp) - shv_x - low_x;
    trig_lo   = low_x < shv_x;
  end

  always_comb begin
    fin_period = held_period;
    fin_count  = count;
    fin_pulse  = pulse;
    if (trig_hi) begin
      if (!pulse) begin
        if (count < CNT_W'(MAX_PERIOD)) begin
          fin_period = (held_amp > min_amp) ? 12'(count) : 12'd0;
        end
        fin_count = '0;
      end
      fin_pulse = 1'b1;
    end
    if (trig_lo) begin
      fin_pulse = 1'b0;
    end
    if (fin_count < CNT_W'(MAX_PERIOD)) begin
      fin_count = fin_count + CNT_W'(1);
    end else begin
      fin_period = 12'd0;
    end
  end

  assign res_period = fin_period;
  assign res_amp    = held_amp;

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    if (load_sample) begin
      sample_r <= sample;
    end
    if (dp_ctrl.wb == WB_INNER) begin
      inner <= inner_sum[34:0];
    end
    if (dp_ctrl.wb == WB_TRIGH) begin
      trig_hi <= low_x > shv_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp          <= '0;
      dc          <= '0;
      band        <= '0;
      low         <= '0;
      envh        <= '0;
      envl        <= '0;
      pulse       <= 1'b0;
      count       <= '0;
      held_period <= '0;
      held_amp    <= '0;
    end else begin
      case (dp_ctrl.wb)
        WB_HP: begin
          hp <= sat32({33'd0, sample_r, 16'd0} - ext32(dc));
        end
        WB_LOW: begin
          low <= sat32(low_x + shv_x);
        end
        WB_DC: begin
          dc <= sat32(ext32(dc) + shv_x);
        end
        WB_BAND: begin
          band <= sat32(ext32(band) + shv_x);
        end
        WB_ENVH: begin
          if (low > envh) begin
            envh     <= low;
            held_amp <= amp_calc(low, envl);
          end else begin
            envh <= sat32(ext32(envh) - shv_x);
          end
        end
        WB_ENVL: begin
          if (low < envl) begin
            envl     <= low;
            held_amp <= amp_calc(envh, low);
          end else begin
            envl <= sat32(ext32(envl) - shv_x);
          end
        end
        WB_FINAL: begin
          held_period <= fin_period;
          count       <= fin_count;
          pulse       <= fin_pulse;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/string_pitch_period_detector_unit.sv =====
// Each accepted sample word is taken at step zero and then runs through nine microcode steps
// that pass eight dependent products one after another through a single shared 35x25
// multiplier with a registered product. The next sample is taken once the sequencer is back
// at step zero. Results leave through an output register, so a new sample can be accepted
// while the previous result word still waits; the last step holds only if that register is
// still full when the next result is ready.
//
// Top level of the string pitch period detector: configuration registers, result register.
// Depends on spd_pkg, spd_sequencer and spd_datapath.
module string_pitch_period_detector_unit
  import spd_pkg::*;
#(
  parameter int unsigned MAX_PERIOD = MAX_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [11:0] sample, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [11:0] period, [24:12] amplitude, [31:25] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [15:0] lp_freq;
  logic [15:0] lp_damp;
  logic [12:0] min_amp;
  logic [15:0] trig_frac;
  logic [23:0] env_decay;

  dp_ctrl_t    dp_ctrl;
  logic        in_ready;
  logic        done;
  logic        out_free;
  logic [11:0] res_period;
  logic [12:0] res_amp;

  assign cfg_ready = 1'b1;
  assign s_tready  = in_ready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lp_freq   <= LP_FREQ_RST;
      lp_damp   <= LP_DAMP_RST;
      min_amp   <= MIN_AMP_RST;
      trig_frac <= TRIG_FRAC_RST;
      env_decay <= ENV_DECAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LP_FREQ:   lp_freq   <= cfg_data[15:0];
        CFG_LP_DAMP:   lp_damp   <= cfg_data[15:0];
        CFG_MIN_AMP:   min_amp   <= cfg_data[12:0];
        CFG_TRIG_FRAC: trig_frac <= cfg_data[15:0];
        CFG_ENV_DECAY: env_decay <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {7'd0, res_amp, res_period};
    end
  end

  spd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .out_free (out_free),
    .done     (done),
    .dp_ctrl  (dp_ctrl)
  );

  spd_datapath #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_ctrl     (dp_ctrl),
    .load_sample (s_tvalid && in_ready),
    .sample      (s_tdata[11:0]),
    .lp_freq     (lp_freq),
    .lp_damp     (lp_damp),
    .min_amp     (min_amp),
    .trig_frac   (trig_frac),
    .env_decay   (env_decay),
    .res_period  (res_period),
    .res_amp     (res_amp)
  );

endmodule

// ===== rtl/core/spd_checker.sv =====
// Port-level checks of the string pitch period detector, attached by the bind below.
// Depends only on the ports of string_pitch_period_detector_unit.
module spd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A sample word occupies the sequencer through its microcode steps before another is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("input taken again too soon after a sample word");

  // A result word never appears in the cycle right after a sample is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result word appeared before the sample was processed");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:25] == 7'd0))
    else $error("padding bits of the result word are not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed or was dropped");

endmodule

bind string_pitch_period_detector_unit spd_checker u_spd_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for string_pitch_period_detector_unit: random and directed sample
// streams are checked against a bit-exact predictor of the filter, envelope and trigger logic.
// Depends on spd_pkg and the detector RTL only.
module tb;
  import spd_pkg::*;

  localparam int unsigned PERIOD_CAP  = MAX_PERIOD_DEF;
  localparam longint      LEAK_Q24    = longint'(HP_LEAK_Q24);
  localparam int          LONG_HOLD   = 200;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE_CYC  = 20;
  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [2:0]  CFG_SPARE_A = 3'd5;
  localparam logic [2:0]  CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [11:0] period;
    logic [12:0] amplitude;
  } pitch_word_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;    // [11:0] sample, [15:12] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;           // [11:0] period, [24:12] amplitude, [31:25] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  string_pitch_period_detector_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Settings as the block should hold them.
  longint cf_freq    = longint'(LP_FREQ_RST);
  longint cf_damp    = longint'(LP_DAMP_RST);
  longint cf_min_amp = longint'(MIN_AMP_RST);
  longint cf_frac    = longint'(TRIG_FRAC_RST);
  longint cf_decay   = longint'(ENV_DECAY_RST);

  // Filter and trigger state, Q16.16 where it is a signal.
  int dc_est, bp, lp, env_hi, env_lo;
  bit pulse;
  int count, held_period, held_amp;

  logic [11:0]  feed_q[$];
  pitch_word_t  due_q[$];
  pitch_word_t  head_word;
  int           fail_count  = 0;
  bit           tail_calm   = 1'b0;
  int           hold_asks   = 0;
  int           hold_served = 0;
  int           gap_left    = 0;
  int           hold_left   = 0;

  function automatic int clip_q16(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int span_counts(input int hi, input int lo);
    longint d;
    d = (longint'(hi) - longint'(lo)) >>> 16;
    if (d < 0) d = 0;
    if (d > 8191) d = 8191;
    return int'(d);
  endfunction

  // One sample through high-pass, state-variable low-pass, envelopes and the trigger.
  function automatic pitch_word_t track_pitch(input logic [11:0] smp);
    longint      x, hp, inner;
    pitch_word_t r;
    x  = longint'(smp) * 65536;
    hp = clip_q16(x - dc_est);
    dc_est = clip_q16(dc_est + ((hp * LEAK_Q24) >>> 24));
    lp = clip_q16(lp + ((cf_freq * bp) >>> 16));
    inner = hp - ((bp * cf_damp) >>> 14) - lp;
    bp = clip_q16(bp + ((cf_freq * inner) >>> 16));

    if (lp > env_hi) begin
      env_hi = lp;
      held_amp = span_counts(env_hi, env_lo);
    end else begin
      env_hi = clip_q16(env_hi - ((env_hi * cf_decay) >>> 24));
    end
    if (lp < env_lo) begin
      env_lo = lp;
      held_amp = span_counts(env_hi, env_lo);
    end else begin
      env_lo = clip_q16(env_lo - ((env_lo * cf_decay) >>> 24));
    end

    if (lp > ((env_hi * cf_frac) >>> 16)) begin
      if (!pulse) begin
        if (count < PERIOD_CAP) held_period = (held_amp > cf_min_amp) ? count : 0;
        count = 0;
      end
      pulse = 1'b1;
    end
    if (lp < ((env_lo * cf_frac) >>> 16)) pulse = 1'b0;

    if (count < PERIOD_CAP) count++;
    else held_period = 0;

    r.period    = held_period[11:0];
    r.amplitude = held_amp[12:0];
    return r;
  endfunction

  // Sender: offers queued samples, with random gaps until the tail of the run.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) due_q.push_back(track_pitch(s_tdata[11:0]));
      if (!s_tvalid || s_tready) begin
        if (gap_left == 0 && !tail_calm && $urandom_range(0, 11) == 0)
          gap_left = $urandom_range(1, 17);
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          s_tdata  <= {4'b0, feed_q.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls in bursts, or for a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          $error("result word %h with nothing expected", m_tdata);
          fail_count++;
        end else begin
          head_word = due_q.pop_front();
          if (m_tdata[11:0] !== head_word.period) begin
            $error("period: expected %0d, got %0d", head_word.period, m_tdata[11:0]);
            fail_count++;
          end
          if (m_tdata[24:12] !== head_word.amplitude) begin
            $error("amplitude: expected %0d, got %0d", head_word.amplitude, m_tdata[24:12]);
            fail_count++;
          end
          if (m_tdata[31:25] !== 7'd0) begin
            $error("padding: expected 0, got %0h", m_tdata[31:25]);
            fail_count++;
          end
        end
      end
      if (hold_served < hold_asks) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !tail_calm && $urandom_range(0, 15) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LP_FREQ:   cf_freq    = longint'(val[15:0]);
      CFG_LP_DAMP:   cf_damp    = longint'(val[15:0]);
      CFG_MIN_AMP:   cf_min_amp = longint'(val[12:0]);
      CFG_TRIG_FRAC: cf_frac    = longint'(val[15:0]);
      CFG_ENV_DECAY: cf_decay   = longint'(val);
      default: ;
    endcase
  endtask

  // Writes every register; the bits above each register's width carry junk.
  task automatic load_setting(input logic [15:0] freq, input logic [15:0] damp,
                              input logic [12:0] min_amp, input logic [15:0] frac,
                              input logic [23:0] decay);
    logic [31:0] junk;
    junk = $urandom();
    set_reg(CFG_LP_FREQ, {junk[7:0], freq});
    set_reg(CFG_LP_DAMP, {junk[15:8], damp});
    set_reg(CFG_MIN_AMP, {junk[26:16], min_amp});
    set_reg(CFG_TRIG_FRAC, {junk[31:24], frac});
    set_reg(CFG_ENV_DECAY, decay);
  endtask

  // Mostly square and triangle bursts of a few periods each, with some noise between.
  task automatic add_waves(input int total, input int pmin, input int pmax);
    int made, per, amp, mid, len, shape, i, ph, v;
    made = 0;
    while (made < total) begin
      per   = $urandom_range(pmin, pmax);
      amp   = $urandom_range(0, 2047);
      mid   = $urandom_range(amp, 4095 - amp);
      shape = $urandom_range(0, 7);
      len   = per * $urandom_range(2, 6);
      if (len > total - made) len = total - made;
      for (i = 0; i < len; i++) begin
        ph = i % per;
        case (shape)
          0, 1, 2: v = (ph < per / 2) ? mid + amp : mid - amp;
          3, 4, 5: v = mid - amp + (4 * amp * ((ph < per / 2) ? ph : per - ph)) / per;
          6:       v = $urandom_range(0, 4095);
          default: v = $urandom_range(0, 1) ? 4095 : 0;
        endcase
        feed_q.push_back(v[11:0]);
      end
      made += len;
    end
  endtask

  // Sender pause: everything offered, accepted and answered, then an idle settling wait.
  task automatic settle();
    do @(negedge clk); while (feed_q.size() > 0 || s_tvalid || due_q.size() > 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A silent input from reset never triggers, so the period stays at zero.
    for (k = 0; k < 100; k++) feed_q.push_back(12'd0);
    settle();

    for (k = 0; k < 3; k++) begin
      feed_q.push_back(12'h000);
      feed_q.push_back(12'hfff);
    end
    feed_q.push_back(12'h800);
    feed_q.push_back(12'h7ff);
    feed_q.push_back(12'haaa);
    feed_q.push_back(12'h555);
    for (k = 0; k < 12; k++) feed_q.push_back(12'd1 << k);
    settle();

    load_setting(LP_FREQ_RST, LP_DAMP_RST, MIN_AMP_RST, TRIG_FRAC_RST, ENV_DECAY_RST);
    set_reg(CFG_SPARE_A, 24'($urandom()));
    set_reg(CFG_SPARE_B, 24'($urandom()));
    add_waves(250, 8, 300);
    hold_asks++;
    settle();

    load_setting(16'hffff, 16'hffff, 13'h1fff, 16'hffff, 24'hffffff);
    add_waves(150, 8, 300);
    settle();

    load_setting(16'd0, 16'd0, 13'd0, 16'd0, 24'd0);
    add_waves(150, 8, 300);
    settle();

    load_setting(16'($urandom_range(2000, 30000)), 16'($urandom_range(0, 30000)),
                 13'($urandom_range(0, 400)), 16'($urandom_range(30000, 65535)),
                 24'($urandom_range(0, 200000)));
    add_waves(300, 8, 300);
    hold_asks++;
    settle();

    // No damping and a drive near resonance: the filter rings up into saturation.
    load_setting(16'd20000, 16'd0, 13'($urandom_range(0, 8191)),
                 16'($urandom_range(0, 65535)), 24'($urandom_range(0, 1000)));
    add_waves(150, 16, 26);
    settle();

    tail_calm = 1'b1;
    load_setting(16'($urandom_range(1000, 40000)), 16'($urandom_range(2000, 20000)),
                 13'($urandom_range(0, 300)), 16'($urandom_range(20000, 65535)),
                 24'($urandom_range(1000, 300000)));
    add_waves(250, 8, 300);
    settle();

    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Ends the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule
